// File: rtl/hcbp_pkg.sv
// hcbp_pkg: shared types and constants of the huffman code bit packer
`timescale 1ns / 1ps
package hcbp_pkg;

  localparam int CODE_W     = 16;              // code_bits field
  localparam int LEN_W      = 5;               // code_len field
  localparam int ENTRY_W    = LEN_W + CODE_W;  // table entry: {len, code}
  localparam int BYTE_W     = 8;
  localparam int PEND_W     = 7;               // bits that never form a full byte
  localparam int PCNT_W     = 3;
  localparam int ACC_W      = CODE_W + PEND_W; // pending bits followed by one code
  localparam int TOTAL_W    = 5;               // up to 7 + 16 bits
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // words produced by one item: the last of them carries tlast
  typedef struct packed {
    logic [1:0]        n;
    logic [BYTE_W-1:0] first_word;
    logic [BYTE_W-1:0] second_word;
  } push_t;

endpackage

// File: rtl/huffman_code_bit_packer_core.sv
// huffman_code_bit_packer_core: table lookup huffman encoder with byte packing
//
//  channel  | dir | fields (tdata from bit 0 up)                       | notes
//  s_axis   | in  | action[1:0] symbol[9:2] code_bits[25:10] code_len[30:26] | 32-bit tdata
//  m_axis   | out | out_byte[7:0], tlast = last word of an item        | 8-bit tdata
//
// one item is taken per cycle while input ready is high; an accepted item
// passes the code table read, then the packer stage, into the output queue
// an encode can give two words, and the output moves one word per cycle while
// m_axis_tready is high, so a run of such items is slowed by the output queue
// rst is synchronous and clears the accumulator, stage valid and queue
// pointers; the code table is not cleared and holds garbage until loaded
// m_axis_tready low stalls the packer stage once the queue has under two
// free places, and input ready drops with it
`timescale 1ns / 1ps
module huffman_code_bit_packer_core
  import hcbp_pkg::*;
#(
  parameter int SYMBOLS      = 256,
  parameter int MAX_CODE_LEN = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // action, symbol, code_bits, code_len, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  output logic        m_axis_tlast
);

  localparam int AW        = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // input word fields
  action_t           in_action;
  logic [7:0]        in_symbol;
  logic [CODE_W-1:0] in_code_bits;
  logic [LEN_W-1:0]  in_code_len;

  assign in_action    = action_t'(s_axis_tdata[1:0]);
  assign in_symbol    = s_axis_tdata[9:2];
  assign in_code_bits = s_axis_tdata[25:10];
  assign in_code_len  = s_axis_tdata[30:26];

  logic               accept;
  logic               in_sym_ok;
  logic [LEN_W-1:0]   load_len;
  logic [CODE_W-1:0]  load_code;
  logic               ram_en;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;

  // packer stage
  logic    s1_valid;
  action_t s1_action;
  logic    s1_sym_ok;
  logic    s1_ready;
  logic    s1_fire;
  push_t   push;

  assign in_sym_ok = {1'b0, in_symbol} < 9'(SYMBOLS);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign s1_fire   = s1_valid && s1_ready;
  // a held stage keeps its table data because the ram only reads on accept
  assign s_axis_tready = !s1_valid || s1_ready;

  // long lengths saturate, stray bits above the length are dropped
  assign load_len  = (in_code_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : in_code_len;
  assign load_code = in_code_bits & CODE_W'((17'(1) << load_len) - 17'(1));

  // a load written at one edge is seen by an encode read at the next
  assign ram_en = accept && in_sym_ok && (in_action == ACT_LOAD || in_action == ACT_ENCODE);
  assign ram_we = accept && in_sym_ok && in_action == ACT_LOAD;

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOLS)
  ) u_code_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (in_symbol[AW-1:0]),
    .wdata ({load_len, load_code}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= in_action;
      s1_sym_ok <= in_sym_ok;
    end
  end

  hcbp_packer u_packer (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_fire),
    .action (s1_action),
    .sym_ok (s1_sym_ok),
    .entry  (ram_rdata),
    .push   (push)
  );

  hcbp_out_fifo u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .space2  (s1_ready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_word  (m_axis_tdata),
    .m_last  (m_axis_tlast)
  );

endmodule

// File: rtl/hcbp_ram.sv
// hcbp_ram: generic single-port ram with registered read
`timescale 1ns / 1ps
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/hcbp_packer.sv
// hcbp_packer: bit accumulator that merges looked-up codes into bytes
`timescale 1ns / 1ps
module hcbp_packer
  import hcbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  action_t            action,
  input  logic               sym_ok,
  input  logic [ENTRY_W-1:0] entry,
  output push_t              push
);

  logic [PEND_W-1:0]  pbits;
  logic [PCNT_W-1:0]  pcount;
  logic [PEND_W-1:0]  pbits_next;
  logic [PCNT_W-1:0]  pcount_next;
  logic [LEN_W-1:0]   entry_len;
  logic [LEN_W-1:0]   clen;
  logic [CODE_W-1:0]  code;
  logic [ACC_W-1:0]   acc;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] rem;
  logic [PEND_W-1:0]  rem_mask;
  logic [PEND_W-1:0]  pmask;

  always_comb begin
    entry_len = sym_ok ? entry[ENTRY_W-1:CODE_W] : '0;
    clen      = (entry_len > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : entry_len;
    code      = sym_ok ? entry[CODE_W-1:0] : '0;
    code      = code & CODE_W'((17'(1) << clen) - 17'(1));
    acc       = (ACC_W'(pbits) << clen) | ACC_W'(code);
    total     = TOTAL_W'(pcount) + TOTAL_W'(clen);

    push        = '0;
    pbits_next  = pbits;
    pcount_next = pcount;
    rem         = total;
    rem_mask    = '0;
    case (action)
      ACT_ENCODE: begin
        if (total >= TOTAL_W'(16)) begin
          push.n           = 2'd2;
          push.first_word  = BYTE_W'(acc >> (total - TOTAL_W'(8)));
          push.second_word = BYTE_W'(acc >> (total - TOTAL_W'(16)));
          rem              = total - TOTAL_W'(16);
        end else if (total >= TOTAL_W'(8)) begin
          push.n          = 2'd1;
          push.first_word = BYTE_W'(acc >> (total - TOTAL_W'(8)));
          rem             = total - TOTAL_W'(8);
        end
        rem_mask    = PEND_W'((8'(1) << rem[PCNT_W-1:0]) - 8'(1));
        pbits_next  = PEND_W'(acc) & rem_mask;
        pcount_next = rem[PCNT_W-1:0];
      end
      ACT_FLUSH: begin
        // zero pad the pending bits up to a whole byte
        push.n          = 2'd1;
        push.first_word = BYTE_W'(15'(pbits) << (4'd8 - 4'(pcount)));
        pbits_next      = '0;
        pcount_next     = '0;
      end
      default: begin
      end
    endcase
    if (!fire) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pbits  <= '0;
      pcount <= '0;
    end else if (fire) begin
      pbits  <= pbits_next;
      pcount <= pcount_next;
    end
  end

  assign pmask = PEND_W'((8'(1) << pcount) - 8'(1));

  // pending bits above the count stay clear
  a_pend_clean: assert property (@(posedge clk) disable iff (rst)
    (pbits & ~pmask) == '0)
    else $error("pending bits set above pending count");

  // a flush leaves nothing pending
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && action == ACT_FLUSH) |=> (pcount == '0 && pbits == '0))
    else $error("flush did not clear accumulator");

  // a flush always gives exactly one word
  a_flush_one: assert property (@(posedge clk) disable iff (rst)
    (fire && action == ACT_FLUSH) |-> push.n == 2'd1)
    else $error("flush word count wrong");

endmodule

// File: rtl/hcbp_out_fifo.sv
// hcbp_out_fifo: small output queue taking up to two words per cycle
`timescale 1ns / 1ps
module hcbp_out_fifo
  import hcbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  push_t             push,
  output logic              space2,
  output logic              m_valid,
  input  logic              m_ready,
  output logic [BYTE_W-1:0] m_word,
  output logic              m_last
);

  logic [BYTE_W:0]      mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic [FIFO_AW-1:0]   wr_ptr1;
  logic                 pop;

  assign wr_ptr1 = wr_ptr + FIFO_AW'(1);
  assign pop     = m_valid && m_ready;
  assign m_valid = count != '0;
  assign space2  = count <= FIFO_CW'(FIFO_DEPTH - 2);
  assign m_word  = mem[rd_ptr][BYTE_W-1:0];
  assign m_last  = mem[rd_ptr][BYTE_W];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= {push.n == 2'd1, push.first_word};
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr1] <= {1'b1, push.second_word};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(push.n) - FIFO_CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> (4'(count) + 4'(push.n)) <= 4'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CW'(FIFO_DEPTH))
    else $error("output queue count out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && push.n == 2'd0) |=> count == $past(count) - FIFO_CW'(1))
    else $error("queue count did not drop on pop");

endmodule
